// ----- src/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, operation codes and the command type of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int          DEPTH_DEF      = 1024;
  localparam int          DATA_WIDTH_DEF = 16;
  localparam int          CAP_W          = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam int          MODE_W         = 3;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NOP        = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic exec;  // apply the operation of the accepted beat
    logic rd;    // read front and rear entries
    logic ld;    // load the result register
  } cmd_t;

endpackage

// ----- src/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: accept one beat, run the operation, read back, hand over result.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait until the result register is free
        if (out_free) begin
          cmd.ld        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/bdq_dpath.sv -----
// ----------------------------------------------------------------------------
// bdq_dpath
// Ring buffer store, head and count registers, capacity and result register.
// ----------------------------------------------------------------------------
module bdq_dpath
  import bdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_data,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [DATA_WIDTH-1:0] in_push_value,
  output logic                  out_accepted,
  output logic [DATA_WIDTH-1:0] out_front_value,
  output logic [DATA_WIDTH-1:0] out_rear_value,
  output logic                  out_is_empty,
  output logic                  out_is_full
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW-1:0]   LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]     DEPTH_S  = (AW + 1)'(DEPTH);
  localparam logic [CMPW-1:0] DEPTH_C  = CMPW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CAP_W-1:0]      cap_r;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  ok_r, ok_nxt;
  logic [DATA_WIDTH-1:0] rd_front_r, rd_rear_r;

  logic [CMPW-1:0]       cap_eff, count_c;
  logic                  has_room, non_empty;
  logic [AW:0]           tail_sum, rear_sum;
  logic [AW-1:0]         tail_idx, rear_idx;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;

  assign cap_eff   = (CMPW'(cap_r) > DEPTH_C) ? DEPTH_C : CMPW'(cap_r);
  assign count_c   = CMPW'(count_r);
  assign has_room  = count_c < cap_eff;
  assign non_empty = (count_r != '0);

  // slot after the rear and the rear slot itself, wrapped once
  assign tail_sum = (AW + 1)'(head_r) + (AW + 1)'(count_r);
  assign rear_sum = tail_sum - (AW + 1)'(1);
  assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign rear_idx = (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail_idx;
    unique case (in_mode)
      MODE_PUSH_FRONT: begin
        if (has_room) begin
          head_nxt  = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
          wr_en     = 1'b1;
          wr_addr   = head_nxt;
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (has_room) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (non_empty) begin
          head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
          count_nxt = count_r - CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (non_empty) begin
          count_nxt = count_r - CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      MODE_NOP: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r <= ok_nxt;
    end
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= in_push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_front_r <= mem[head_r];
      rd_rear_r  <= mem[rear_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      out_accepted    <= ok_r;
      out_front_value <= non_empty ? rd_front_r : '0;
      out_rear_value  <= non_empty ? rd_rear_r : '0;
      out_is_empty    <= !non_empty;
      out_is_full     <= !has_room;
    end
  end

endmodule

// ----- src/bounded_double_ended_queue_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Deque of configurable capacity held in a ring buffer memory.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_mode, in_push_value
//  out     | out_valid/out_stall| out_accepted, out_front_value, out_rear_value,
//          |                    | out_is_empty, out_is_full
//  cfg     | cfg_valid/cfg_ready| cfg_data (capacity)
//
// after its input beat a result passes the operation and store write, the
// registered store read and the load of the result register, in that order
// a new item is taken only when the sequencer is idle again after the load
// a stalled result holds the sequencer in its load step, delaying the next beat
// reset clears head and count and sets capacity to 1024; the store is not cleared
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit
  import bdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [DATA_WIDTH-1:0] in_push_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [DATA_WIDTH-1:0] out_front_value,
  output logic [DATA_WIDTH-1:0] out_rear_value,
  output logic                  out_is_empty,
  output logic                  out_is_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bdq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_mode         (in_mode),
    .in_push_value   (in_push_value),
    .out_accepted    (out_accepted),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

endmodule

// ----- src/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker
  import bdq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_accepted,
  input logic [DATA_WIDTH-1:0] out_front_value,
  input logic [DATA_WIDTH-1:0] out_rear_value,
  input logic                  out_is_empty,
  input logic                  out_is_full
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accepted)
      && $stable(out_front_value) && $stable(out_rear_value)
      && $stable(out_is_empty) && $stable(out_is_full))
    else $error("result changed while stalled");

  // one item in flight: the beat after an accepted one is stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

  // empty deque reports zero front and rear
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_front_value == '0 && out_rear_value == '0)
    else $error("nonzero value on empty deque");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_double_ended_queue_unit bdq_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_bdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_accepted    (out_accepted),
  .out_front_value (out_front_value),
  .out_rear_value  (out_rear_value),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full)
);
